### rtl/rca_pkg.sv
// Package for the ring chunk allocator: field widths, request and status codes,
// controller states and the command/status structs between controller and datapath.
// Depends on nothing; every other file of the block except rca_ram imports it.
package rca_pkg;

   localparam int PTR_W               = 13;
   localparam int TYPE_W              = 2;
   localparam int STATUS_W            = 3;
   localparam int BUF_BYTES_DEFAULT   = 4096;
   localparam int HEADER_BYTES_DEFAULT = 4;
   localparam int RING_SIZE_RESET     = 4096;

   typedef enum logic [TYPE_W-1:0] {
      REQ_ALLOC = 2'd0,
      REQ_UNDO  = 2'd1,
      REQ_FREE  = 2'd2,
      REQ_QUERY = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NOSPACE  = 3'd1,
      ST_BADPTR   = 3'd2,
      ST_BADORDER = 3'd3,
      ST_BADSIZE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR = 2'd0,
      S_IDLE  = 2'd1,
      S_EXEC  = 2'd2
   } state_type;

   typedef struct packed {
      logic accept;      // capture request, start header read
      logic clear_step;  // write one zero header during the clearing pass
      logic commit;      // evaluate request, update pointers, load result
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;  // last header of the clearing pass is being written
   } dp_status_type;

endpackage

### rtl/rca_req_if.sv
// Request channel of the ring chunk allocator: valid/ready plus the request fields.
// Depends on rca_pkg for the field widths.
interface rca_req_if;
   import rca_pkg::*;

   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [PTR_W-1:0]  req_size;
   logic [PTR_W-1:0]  chunk_offset;

   modport source (output valid, req_type, req_size, chunk_offset, input ready);
   modport sink   (input valid, req_type, req_size, chunk_offset, output ready);
endinterface

### rtl/rca_rsp_if.sv
// Response channel of the ring chunk allocator: valid/ready plus the result fields.
// Depends on rca_pkg for the field widths.
interface rca_rsp_if;
   import rca_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PTR_W-1:0]    granted_offset;
   logic [PTR_W-1:0]    largest_free;

   modport source (output valid, status, granted_offset, largest_free, input ready);
   modport sink   (input valid, status, granted_offset, largest_free, output ready);
endinterface

### rtl/ring_chunk_allocator.sv
// Top level of the ring chunk allocator: controller, datapath and channel wiring.
// Depends on rca_pkg, rca_req_if, rca_rsp_if, rca_ram, rca_ctrl and rca_dpath.
//
//   channel   direction  transaction carries
//   req_chan  in         req_type, req_size, chunk_offset
//   rsp_chan  out        status, granted_offset, largest_free
//   csr_*     in         buffer_size write (csr_wr_en, csr_wr_data)
//
// Each request runs in two steps: accept plus header read from the synchronous
// header RAM, then evaluate and update the pointers; one request is in work at a time.
// After reset a clearing pass zeroes the header RAM with req ready low; CSR writes
// are taken throughout.
// A result waits in the output register while the next request is accepted; the
// evaluate step stalls only while that register still holds an untaken result.
module ring_chunk_allocator #(
   parameter int BUF_BYTES    = rca_pkg::BUF_BYTES_DEFAULT,
   parameter int HEADER_BYTES = rca_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   rca_req_if.sink                   req_chan,
   rca_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [rca_pkg::PTR_W-1:0] csr_wr_data
);
   import rca_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // sequence clearing, accept and commit
   rca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // hold ring pointers and headers, evaluate each transaction
   rca_dpath #(
      .BUF_BYTES    (BUF_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .dp_status          (dp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_type           (req_chan.req_type),
      .req_size           (req_chan.req_size),
      .chunk_offset       (req_chan.chunk_offset),
      .rsp_status         (rsp_chan.status),
      .rsp_granted_offset (rsp_chan.granted_offset),
      .rsp_largest_free   (rsp_chan.largest_free)
   );
endmodule

### rtl/rca_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module rca_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/rca_ctrl.sv
// Controller of the ring chunk allocator: clearing pass, request sequencing and
// response valid. Depends on rca_pkg for states and the command/status structs.
module rca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rca_pkg::dp_status_type dp_status,
   output rca_pkg::ctrl_cmd_type  cmd
);
   import rca_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_commit;

   assign can_commit = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (dp_status.clear_done) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_EXEC;
         S_EXEC:  if (can_commit) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.clear_step = 1'b0;
      cmd.commit     = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.clear_step = 1'b1;
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_EXEC:  cmd.commit = can_commit;
         default: ;
      endcase
   end

   // hold the result until taken; a commit reloads it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### rtl/rca_dpath.sv
// Datapath of the ring chunk allocator: ring registers, header store, request
// evaluation and result registers. Depends on rca_pkg and rca_ram.
module rca_dpath #(
   parameter int BUF_BYTES    = rca_pkg::BUF_BYTES_DEFAULT,
   parameter int HEADER_BYTES = rca_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rca_pkg::ctrl_cmd_type         cmd,
   output rca_pkg::dp_status_type        dp_status,
   input  logic                          csr_wr_en,
   input  logic [rca_pkg::PTR_W-1:0]     csr_wr_data,
   input  logic [rca_pkg::TYPE_W-1:0]    req_type,
   input  logic [rca_pkg::PTR_W-1:0]     req_size,
   input  logic [rca_pkg::PTR_W-1:0]     chunk_offset,
   output logic [rca_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rca_pkg::PTR_W-1:0]     rsp_granted_offset,
   output logic [rca_pkg::PTR_W-1:0]     rsp_largest_free
);
   import rca_pkg::*;

   localparam int AW = $clog2(BUF_BYTES);
   localparam logic [PTR_W-1:0] HB  = PTR_W'(HEADER_BYTES);
   localparam logic [PTR_W:0]   HBW = (PTR_W+1)'(HEADER_BYTES);
   localparam logic [PTR_W-1:0] SIZE_RESET =
      PTR_W'((RING_SIZE_RESET > BUF_BYTES) ? BUF_BYTES : RING_SIZE_RESET);

   function automatic logic [AW-1:0] to_addr(input logic [PTR_W-1:0] pos);
      logic [AW+PTR_W-1:0] ext;
      ext = {{AW{1'b0}}, pos};
      return ext[AW-1:0];
   endfunction

   logic [PTR_W-1:0]    bsize_ff, bsize_in;
   logic [PTR_W-1:0]    rp_ff, rp_in;
   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic                full_ff, full_in;
   logic [TYPE_W-1:0]   type_ff;
   logic [PTR_W-1:0]    size_ff;
   logic [PTR_W-1:0]    off_ff;
   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [STATUS_W-1:0] status_ff;
   logic [PTR_W-1:0]    granted_ff;
   logic [PTR_W-1:0]    largest_ff;

   logic                hdr_we;
   logic [AW-1:0]       hdr_waddr;
   logic [PTR_W-1:0]    hdr_wdata;
   logic [PTR_W-1:0]    hdr_len;

   status_type          status_c;
   logic [PTR_W-1:0]    granted_c, largest_c;
   logic                alloc_we;
   logic [PTR_W-1:0]    alloc_start;

   // alloc terms
   logic [PTR_W:0]      need;
   logic [PTR_W-1:0]    room_tail, head_start, room_head, wp_tail, wp_head;
   logic                fit_tail, fit_head;
   // undo/free terms
   logic [PTR_W-1:0]    pos, end_undo, end_free, rp_next;
   logic [PTR_W:0]      pos_end;
   logic                bad_ptr;

   assign dp_status.clear_done = (clr_cnt_ff == AW'(BUF_BYTES - 1));

   rca_ram #(.WIDTH(PTR_W), .DEPTH(BUF_BYTES)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hdr_waddr),
      .wr_data (hdr_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (to_addr(chunk_offset - HB)),
      .rd_data (hdr_len)
   );

   assign hdr_we    = cmd.clear_step || alloc_we;
   assign hdr_waddr = cmd.clear_step ? clr_cnt_ff : to_addr(alloc_start);
   assign hdr_wdata = cmd.clear_step ? '0 : need[PTR_W-1:0];
   assign clr_cnt_in = cmd.clear_step ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   always_comb begin
      need       = {1'b0, size_ff} + HBW;
      room_tail  = bsize_ff - wp_ff;
      fit_tail   = (wp_ff >= rp_ff) && ({1'b0, room_tail} >= need);
      head_start = (wp_ff <= rp_ff) ? wp_ff : '0;
      room_head  = rp_ff - head_start;
      fit_head   = ({1'b0, room_head} >= need);
      wp_tail    = wp_ff + need[PTR_W-1:0];
      wp_head    = head_start + need[PTR_W-1:0];

      pos        = off_ff - HB;
      pos_end    = {1'b0, pos} + {1'b0, hdr_len};
      bad_ptr    = (off_ff < HB) || (pos >= bsize_ff);
      end_undo   = (wp_ff == '0) ? bsize_ff : wp_ff;
      end_free   = (wp_ff > rp_ff) ? wp_ff : bsize_ff;
      rp_next    = (pos_end[PTR_W-1:0] == bsize_ff) ? '0 : pos_end[PTR_W-1:0];
   end

   always_comb begin
      status_c    = ST_OK;
      granted_c   = '0;
      largest_c   = '0;
      alloc_we    = 1'b0;
      alloc_start = wp_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      full_in     = full_ff;
      bsize_in    = bsize_ff;

      unique case (req_code_type'(type_ff))
         REQ_ALLOC: begin
            if (full_ff) begin
               status_c = ST_NOSPACE;
            end else if (fit_tail) begin
               alloc_start = wp_ff;
               wp_in       = (wp_tail == bsize_ff) ? '0 : wp_tail;
               full_in     = (wp_in == rp_ff);
               alloc_we    = cmd.commit;
               granted_c   = wp_ff + HB;
            end else if (fit_head) begin
               alloc_start = head_start;
               wp_in       = wp_head;
               full_in     = (wp_head == rp_ff);
               alloc_we    = cmd.commit;
               granted_c   = head_start + HB;
            end else begin
               status_c = ST_NOSPACE;
            end
         end
         REQ_UNDO: begin
            if (bad_ptr || (pos_end != {1'b0, end_undo})) begin
               status_c = ST_BADPTR;
            end else begin
               wp_in   = pos;
               full_in = 1'b0;
            end
         end
         REQ_FREE: begin
            if (bad_ptr) begin
               status_c = ST_BADPTR;
            end else if ((pos != rp_ff) && (pos != '0)) begin
               status_c = ST_BADORDER;
            end else if (pos_end > {1'b0, end_free}) begin
               status_c = ST_BADSIZE;
            end else begin
               // ring empties: restart both pointers at zero
               rp_in   = (rp_next == wp_ff) ? '0 : rp_next;
               wp_in   = (rp_next == wp_ff) ? '0 : wp_ff;
               full_in = 1'b0;
            end
         end
         REQ_QUERY: begin
            if (full_ff) begin
               largest_c = '0;
            end else if (wp_ff >= rp_ff) begin
               largest_c = (room_tail < rp_ff) ? rp_ff : room_tail;
            end else begin
               largest_c = rp_ff - wp_ff;
            end
         end
         default: ;
      endcase

      if (!cmd.commit) begin
         rp_in   = rp_ff;
         wp_in   = wp_ff;
         full_in = full_ff;
      end

      // a size write restarts the ring; the header store is kept
      if (csr_wr_en) begin
         bsize_in = ({19'd0, csr_wr_data} > BUF_BYTES) ? PTR_W'(BUF_BYTES) : csr_wr_data;
         rp_in    = '0;
         wp_in    = '0;
         full_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff   <= SIZE_RESET;
         rp_ff      <= '0;
         wp_ff      <= '0;
         full_ff    <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         bsize_ff   <= bsize_in;
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
         full_ff    <= full_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff <= req_type;
         size_ff <= req_size;
         off_ff  <= chunk_offset;
      end
      if (cmd.commit) begin
         status_ff  <= status_c;
         granted_ff <= (status_c == ST_OK) ? granted_c : '0;
         largest_ff <= largest_c;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_granted_offset = granted_ff;
   assign rsp_largest_free   = largest_ff;
endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for ring_chunk_allocator: a ring ledger class predicts every response,
// plain tasks drive the request, response and CSR ports under random idling.
// Depends on rca_pkg, rca_req_if, rca_rsp_if and the RTL of the block.

import rca_pkg::*;

typedef struct packed {
   status_type       status;
   logic [PTR_W-1:0] granted;
   logic [PTR_W-1:0] largest;
} ring_result_type;

class ring_ledger;
   localparam int unsigned HDR  = HEADER_BYTES_DEFAULT;
   localparam int unsigned RING = BUF_BYTES_DEFAULT;

   int unsigned      ring_bytes;
   int unsigned      rd_ptr;
   int unsigned      wr_ptr;
   bit               ring_full;
   logic [PTR_W-1:0] chunk_len [RING];
   ring_result_type  owed[$];
   int unsigned      live_chunks[$];   // payload offsets, oldest first
   int unsigned      fail_count;
   int unsigned      checked;
   int unsigned      ring_writes;
   int unsigned      op_count[4];
   int unsigned      status_seen[5];

   function new();
      foreach (chunk_len[i]) chunk_len[i] = '0;
      ring_bytes = RING;
      rd_ptr     = 0;
      wr_ptr     = 0;
      ring_full  = 1'b0;
   endfunction

   function void set_ring(logic [PTR_W-1:0] value);
      int unsigned v;
      v = value;
      if (v > RING) v = RING;
      ring_bytes = v;
      rd_ptr     = 0;
      wr_ptr     = 0;
      ring_full  = 1'b0;
      live_chunks.delete();
      ring_writes++;
   endfunction

   function status_type take_chunk(int unsigned size, output int unsigned offset);
      int unsigned need;
      int unsigned start;
      need   = size + HDR;
      offset = 0;
      if (ring_full) return ST_NOSPACE;
      // tail room first
      if (wr_ptr >= rd_ptr && ring_bytes - wr_ptr >= need) begin
         start  = wr_ptr;
         wr_ptr = wr_ptr + need;
         if (wr_ptr == ring_bytes) wr_ptr = 0;
         if (wr_ptr == rd_ptr) ring_full = 1'b1;
         chunk_len[start] = PTR_W'(need);
         offset = start + HDR;
         return ST_OK;
      end
      // then the room in front of the oldest chunk
      start = (wr_ptr <= rd_ptr) ? wr_ptr : 0;
      if (rd_ptr - start >= need) begin
         wr_ptr = start + need;
         if (wr_ptr == rd_ptr) ring_full = 1'b1;
         chunk_len[start] = PTR_W'(need);
         offset = start + HDR;
         return ST_OK;
      end
      return ST_NOSPACE;
   endfunction

   function status_type undo_chunk(int unsigned off);
      int unsigned pos;
      int unsigned tail;
      if (off < HDR) return ST_BADPTR;
      pos = off - HDR;
      if (pos >= ring_bytes) return ST_BADPTR;
      tail = (wr_ptr == 0) ? ring_bytes : wr_ptr;
      if (pos + chunk_len[pos] != tail) return ST_BADPTR;
      wr_ptr    = pos;
      ring_full = 1'b0;
      return ST_OK;
   endfunction

   function status_type release_chunk(int unsigned off);
      int unsigned pos;
      int unsigned tail;
      if (off < HDR) return ST_BADPTR;
      pos = off - HDR;
      if (pos >= ring_bytes) return ST_BADPTR;
      if (pos != rd_ptr && pos != 0) return ST_BADORDER;
      tail = (wr_ptr > rd_ptr) ? wr_ptr : ring_bytes;
      if (pos + chunk_len[pos] > tail) return ST_BADSIZE;
      rd_ptr = pos + chunk_len[pos];
      if (rd_ptr == ring_bytes) rd_ptr = 0;
      if (rd_ptr == wr_ptr) begin
         rd_ptr = 0;
         wr_ptr = 0;
      end
      ring_full = 1'b0;
      return ST_OK;
   endfunction

   function int unsigned widest_span();
      int unsigned a;
      int unsigned b;
      if (ring_full) return 0;
      if (wr_ptr >= rd_ptr) begin
         a = ring_bytes - wr_ptr;
         b = rd_ptr;
      end else begin
         a = rd_ptr - wr_ptr;
         b = a;
      end
      return (a < b) ? b : a;
   endfunction

   function void note_request(req_code_type op, logic [PTR_W-1:0] size,
                              logic [PTR_W-1:0] off);
      ring_result_type r;
      int unsigned     grant;
      r.status  = ST_OK;
      r.granted = '0;
      r.largest = '0;
      grant     = 0;
      case (op)
         REQ_ALLOC: r.status = take_chunk(size, grant);
         REQ_UNDO:  r.status = undo_chunk(off);
         REQ_FREE:  r.status = release_chunk(off);
         default:   r.largest = PTR_W'(widest_span());
      endcase
      if (r.status == ST_OK) begin
         case (op)
            REQ_ALLOC: begin
               r.granted = PTR_W'(grant);
               live_chunks.push_back(grant);
            end
            REQ_UNDO: if (live_chunks.size() != 0) void'(live_chunks.pop_back());
            REQ_FREE: if (live_chunks.size() != 0) void'(live_chunks.pop_front());
            default: ;
         endcase
         if (rd_ptr == 0 && wr_ptr == 0 && !ring_full) live_chunks.delete();
      end
      op_count[int'(op)]++;
      status_seen[int'(r.status)]++;
      owed.push_back(r);
   endfunction

   task report(string msg);
      fail_count++;
      if (fail_count <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   task check_result(logic [STATUS_W-1:0] status, logic [PTR_W-1:0] granted,
                     logic [PTR_W-1:0] largest);
      ring_result_type want;
      if (owed.size() == 0) begin
         report($sformatf("response with nothing outstanding (status %0d)", status));
         return;
      end
      want = owed.pop_front();
      if (status !== want.status)
         report($sformatf("response %0d status %0d, want %0d", checked, status, want.status));
      if (granted !== want.granted)
         report($sformatf("response %0d granted_offset %0d, want %0d",
                          checked, granted, want.granted));
      if (largest !== want.largest)
         report($sformatf("response %0d largest_free %0d, want %0d",
                          checked, largest, want.largest));
      checked++;
   endtask
endclass

module tb;
   // Cycles without any transaction before the run is declared hung; covers the
   // header clearing pass after reset with a wide margin.
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 4;
   localparam int TAIL        = 16;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [PTR_W-1:0] csr_wr_data;
   bit               tx_burst;
   bit               rx_burst;

   rca_req_if req_chan ();
   rca_rsp_if rsp_chan ();

   ring_ledger ledger = new();

   ring_chunk_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Present one request after a random gap and hold it until accepted. Valid is
   // only dropped when a gap follows, so back-to-back transactions keep it high.
   task automatic send_req(req_code_type op, logic [PTR_W-1:0] size,
                           logic [PTR_W-1:0] off);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         if (req_chan.valid) req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= op;
      req_chan.req_size     <= size;
      req_chan.chunk_offset <= off;
      do @(posedge clock); while (!req_chan.ready);
      ledger.note_request(op, size, off);
   endtask

   // Drop valid and hold off until every outstanding response has been taken.
   task automatic hold_until_drained();
      if (req_chan.valid) req_chan.valid <= 1'b0;
      while (ledger.owed.size() != 0) @(posedge clock);
   endtask

   // Drain the block, let it settle, then write buffer_size for one cycle.
   task automatic program_ring(logic [PTR_W-1:0] value);
      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.set_ring(value);
   endtask

   // Mostly well-formed traffic: allocs sized to the ring, frees of the oldest
   // chunk and undos of the newest, with some noise on every field.
   task automatic random_item();
      int unsigned      pick;
      int unsigned      ring;
      int unsigned      room;
      req_code_type     op;
      logic [PTR_W-1:0] size;
      logic [PTR_W-1:0] off;
      ring = ledger.ring_bytes;
      pick = $urandom_range(0, 99);
      // unused fields carry random bits; the block must ignore them
      size = PTR_W'($urandom_range(0, 8191));
      off  = PTR_W'($urandom_range(0, 8191));
      if (pick < 8) begin
         op = req_code_type'($urandom_range(0, 3));
      end else if (pick < 50) begin
         op = REQ_ALLOC;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: size = PTR_W'($urandom_range(0, ring / 8));
            6, 7:             size = PTR_W'($urandom_range(0, ring));
            8: begin
               // exact fit of the tail
               room = ring - ledger.wr_ptr;
               size = PTR_W'((room >= 4) ? room - 4 : 0);
            end
            default: size = PTR_W'((ledger.rd_ptr >= 4) ? ledger.rd_ptr - 4 : 0);
         endcase
      end else if (pick < 78) begin
         op = REQ_FREE;
         case ($urandom_range(0, 9))
            0:       off = PTR_W'(ledger.HDR);           // chunk at offset zero
            1:       ;                                   // keep the random offset
            default: off = PTR_W'(ledger.rd_ptr + ledger.HDR);
         endcase
      end else if (pick < 88) begin
         op = REQ_UNDO;
         if (ledger.live_chunks.size() != 0 && $urandom_range(0, 3) != 0)
            off = PTR_W'(ledger.live_chunks[$]);
         else if (ring != 0)
            off = PTR_W'($urandom_range(0, ring + ledger.HDR));
      end else begin
         op = REQ_QUERY;
      end
      send_req(op, size, off);
   endtask

   // Response side: random stall per response, with stretches of none.
   initial begin : result_sink
      int gap;
      int taken;
      taken = 0;
      rx_burst = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
         gap = rx_burst ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         ledger.check_result(rsp_chan.status, rsp_chan.granted_offset,
                             rsp_chan.largest_free);
         taken++;
      end
   end

   // Hang detection: count cycles in which neither channel moves a transaction.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[%0t] watchdog: %0d cycles without a transaction", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned ring_plan [7] = '{4096, 8, 8191, 0, 64, 1000, 0};
      int          plan_items[7] = '{300, 150, 250, 40, 200, 250, 250};
      int          n;

      // drive every input to a known value before the first edge
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.req_type     <= REQ_ALLOC;
      req_chan.req_size     <= '0;
      req_chan.chunk_offset <= '0;
      tx_burst = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // CSR writes land during the clearing pass; requests wait for ready.
      program_ring(13'd4096);

      // Directed: empty ring, unwritten headers and malformed offsets first.
      send_req(REQ_QUERY, '0, '0);
      send_req(REQ_FREE,  '0, 13'd4);         // header at zero never written
      send_req(REQ_UNDO,  13'h1fff, 13'd0);   // offset below the header
      send_req(REQ_FREE,  '0, 13'd3);
      send_req(REQ_FREE,  '0, 13'h1fff);      // header past the ring end
      send_req(REQ_ALLOC, 13'd0, '0);
      send_req(REQ_ALLOC, 13'd100, '0);
      send_req(REQ_UNDO,  '0, 13'd4);         // not the newest chunk
      send_req(REQ_UNDO,  '0, 13'd8);
      send_req(REQ_FREE,  '0, 13'd50);        // out of order
      send_req(REQ_ALLOC, 13'd4088, '0);      // fills to the ring end: full
      send_req(REQ_ALLOC, 13'd1, '0);         // alloc while full
      send_req(REQ_QUERY, '0, '0);            // query while full
      send_req(REQ_FREE,  '0, 13'd4);
      send_req(REQ_ALLOC, 13'd8, '0);         // front room too small
      send_req(REQ_ALLOC, 13'd0, '0);         // exact front fit: full again
      send_req(REQ_FREE,  '0, 13'd8);
      send_req(REQ_ALLOC, 13'h1fff, '0);      // larger than any ring
      send_req(REQ_ALLOC, 13'd4000, '0);
      send_req(REQ_FREE,  '0, 13'd4);
      send_req(REQ_FREE,  '0, 13'd8);         // ring empties: pointers reset
      send_req(REQ_ALLOC, 13'd500, '0);
      // Shrink the ring under a stale 504-byte header at zero.
      program_ring(13'd100);
      send_req(REQ_FREE,  '0, 13'd4);         // chunk runs past the ring end
      send_req(REQ_ALLOC, 13'd96, '0);        // whole ring in one chunk
      send_req(REQ_QUERY, '0, '0);

      // Random phases over several ring sizes, extremes included; the last
      // phase takes a random size.
      foreach (ring_plan[p]) begin
         if (p == 6) program_ring(PTR_W'($urandom_range(8, 4096)));
         else        program_ring(PTR_W'(ring_plan[p]));
         for (n = 0; n < plan_items[p]; n++) begin
            if (n % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 59) == 0) hold_until_drained();
            random_item();
         end
      end

      hold_until_drained();
      repeat (TAIL) @(posedge clock);

      $display("Covered %0d requests (alloc %0d, undo %0d, free %0d, query %0d) over %0d ring sizes",
               ledger.checked, ledger.op_count[REQ_ALLOC], ledger.op_count[REQ_UNDO],
               ledger.op_count[REQ_FREE], ledger.op_count[REQ_QUERY], ledger.ring_writes);
      $display("Statuses: ok %0d, no space %0d, bad pointer %0d, bad order %0d, bad size %0d",
               ledger.status_seen[ST_OK], ledger.status_seen[ST_NOSPACE],
               ledger.status_seen[ST_BADPTR], ledger.status_seen[ST_BADORDER],
               ledger.status_seen[ST_BADSIZE]);
      if (ledger.fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
